[src/wcc_pkg.sv]
// Package for the watering cycle controller: command and mode codes,
// register indexes, field widths and reset values of the registers.
// No dependencies; every other file of the block imports it.
package wcc_pkg;

  // Field widths
  localparam int CmdW       = 3;
  localparam int MoistW     = 14;
  localparam int SecW       = 16;
  localparam int SinceW     = 17;
  localparam int ModeW      = 2;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 17;

  // Register reset values
  localparam logic [MoistW-1:0] ThresholdRst   = 14'd3000;
  localparam logic [SecW-1:0]   WaterSecRst    = 16'd300;
  localparam logic [SinceW-1:0] MinIntervalRst = 17'd3600;
  localparam logic              AutoEnableRst  = 1'b1;

  // Seconds-since-stop counter saturates here
  localparam logic [SinceW-1:0] SinceStopMax = 17'd86400;

  typedef enum logic [CmdW-1:0] {
    CMD_TICK   = 3'd0,
    CMD_SAMPLE = 3'd1,
    CMD_START  = 3'd2,
    CMD_STOP   = 3'd3,
    CMD_PAUSE  = 3'd4,
    CMD_RESUME = 3'd5
  } cmd_t;

  typedef enum logic [ModeW-1:0] {
    MODE_IDLE     = 2'd0,
    MODE_WATERING = 2'd1,
    MODE_PAUSED   = 2'd2
  } mode_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_THRESHOLD    = 2'd0,
    CFG_WATER_SEC    = 2'd1,
    CFG_MIN_INTERVAL = 2'd2,
    CFG_AUTO_ENABLE  = 2'd3
  } cfg_idx_t;

endpackage

[src/wcc_if.sv]
// Stream interfaces of the watering cycle controller: one for event beats,
// one for result beats. Depends on wcc_pkg for field widths.
interface wcc_in_if;
  import wcc_pkg::*;
  logic              valid;
  logic              ready;
  logic [CmdW-1:0]   command;
  logic [MoistW-1:0] moisture;
  logic [SecW-1:0]   duration;

  modport source (output valid, command, moisture, duration, input ready);
  modport sink   (input valid, command, moisture, duration, output ready);
endinterface

interface wcc_out_if;
  import wcc_pkg::*;
  logic             valid;
  logic             ready;
  logic             pump_on;
  logic             led_on;
  logic [ModeW-1:0] mode;
  logic [SecW-1:0]  remaining_seconds;
  logic             rejected;

  modport source (output valid, pump_on, led_on, mode, remaining_seconds, rejected,
                  input ready);
  modport sink   (input valid, pump_on, led_on, mode, remaining_seconds, rejected,
                  output ready);
endinterface

[src/watering_cycle_controller_core.sv]
// Watering cycle controller top level: input register, event logic, result register.
// Depends on wcc_pkg and the stream interfaces in wcc_if.sv.
//
//   channel   direction  handshake      payload
//   in_bus    sink       valid/ready    command, moisture, duration
//   out_bus   source     valid/ready    pump_on, led_on, mode, remaining_seconds, rejected
//   cfg_*     sink       cfg_we only    cfg_index, cfg_data
//
// One beat per cycle sustained while out_bus.ready holds; each event beat is held
// in the input register and then in the result register.
// Mode and counters are updated as an event moves from the input register into the
// result register, so the next event always sees the state left by the previous one.
// A stalled result register holds the input register; the input side stalls only
// when both registers are full. Synchronous active-low reset clears the mode, the
// counters, the valid flags and loads the register defaults.
module watering_cycle_controller_core (
  input  logic                         clk,
  input  logic                         rst_n,
  wcc_in_if.sink                       in_bus,
  wcc_out_if.source                    out_bus,
  input  logic                         cfg_we,
  input  logic [wcc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [wcc_pkg::CfgDataW-1:0] cfg_data
);
  import wcc_pkg::*;

  // Configuration registers
  logic [MoistW-1:0] threshold_r;
  logic [SecW-1:0]   water_sec_r;
  logic [SinceW-1:0] gap_min_r;
  logic              auto_en_r;

  // Input register
  logic              s1_valid_r;
  logic [CmdW-1:0]   s1_cmd_r;
  logic [MoistW-1:0] s1_moist_r;
  logic [SecW-1:0]   s1_dur_r;

  // Controller state
  mode_t             mode_r, mode_nxt;
  logic [SecW-1:0]   left_r, left_nxt;
  logic [SinceW-1:0] since_r, since_nxt;
  logic              rej_nxt;

  // Result register
  logic              out_valid_r;
  logic [ModeW-1:0]  out_mode_r;
  logic [SecW-1:0]   out_left_r;
  logic              out_rej_r;

  logic              s1_fire;
  logic              in_fire;
  logic [SecW-1:0]   start_secs;

  assign s1_fire   = s1_valid_r && (!out_valid_r || out_bus.ready);
  assign in_bus.ready = !s1_valid_r || s1_fire;
  assign in_fire   = in_bus.valid && in_bus.ready;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r    <= ThresholdRst;
      water_sec_r    <= WaterSecRst;
      gap_min_r      <= MinIntervalRst;
      auto_en_r      <= AutoEnableRst;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_THRESHOLD:    threshold_r    <= cfg_data[MoistW-1:0];
        CFG_WATER_SEC:    water_sec_r    <= cfg_data[SecW-1:0];
        CFG_MIN_INTERVAL: gap_min_r      <= cfg_data[SinceW-1:0];
        CFG_AUTO_ENABLE:  auto_en_r      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Input register captures an event beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r   <= in_bus.command;
      s1_moist_r <= in_bus.moisture;
      s1_dur_r   <= in_bus.duration;
    end
  end

  // A manual start with zero duration falls back to the configured length.
  assign start_secs = (s1_dur_r == '0) ? water_sec_r : s1_dur_r;

  // Event logic: next mode, counters and refusal flag
  always_comb begin
    mode_nxt  = mode_r;
    left_nxt  = left_r;
    since_nxt = since_r;
    rej_nxt   = 1'b0;
    case (cmd_t'(s1_cmd_r))
      CMD_TICK: begin
        if (since_r < SinceStopMax) begin
          since_nxt = since_r + 17'd1;
        end
        if (mode_r == MODE_WATERING) begin
          if (left_r <= 16'd1) begin
            mode_nxt  = MODE_IDLE;
            left_nxt  = '0;
            since_nxt = '0;
          end else begin
            left_nxt = left_r - 16'd1;
          end
        end
      end
      CMD_SAMPLE: begin
        if (auto_en_r && mode_r == MODE_IDLE && since_r >= gap_min_r &&
            s1_moist_r < threshold_r) begin
          mode_nxt = MODE_WATERING;
          left_nxt = water_sec_r;
        end
      end
      CMD_START: begin
        // A running cycle is not restarted; a paused one begins anew.
        if (mode_r != MODE_WATERING) begin
          mode_nxt = MODE_WATERING;
          left_nxt = start_secs;
        end
      end
      CMD_STOP: begin
        mode_nxt  = MODE_IDLE;
        left_nxt  = '0;
        since_nxt = '0;
      end
      CMD_PAUSE: begin
        if (mode_r == MODE_WATERING) begin
          mode_nxt = MODE_PAUSED;
        end else begin
          rej_nxt = 1'b1;
        end
      end
      CMD_RESUME: begin
        if (mode_r == MODE_PAUSED) begin
          mode_nxt = MODE_WATERING;
        end else begin
          rej_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // State moves forward only when the event leaves the input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      left_r  <= '0;
      since_r <= '0;
    end else if (s1_fire) begin
      mode_r  <= mode_nxt;
      left_r  <= left_nxt;
      since_r <= since_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_mode_r <= mode_nxt;
      out_left_r <= left_nxt;
      out_rej_r  <= rej_nxt;
    end
  end

  assign out_bus.valid             = out_valid_r;
  assign out_bus.pump_on           = (out_mode_r == MODE_WATERING);
  assign out_bus.led_on            = (out_mode_r == MODE_WATERING);
  assign out_bus.mode              = out_mode_r;
  assign out_bus.remaining_seconds = out_left_r;
  assign out_bus.rejected          = out_rej_r;

endmodule

[src/wcc_checker.sv]
// Port-level checker for the watering cycle controller, with its bind statement.
// Depends on wcc_pkg for the mode codes and field widths.
module wcc_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      pump_on,
  input logic                      led_on,
  input logic [wcc_pkg::ModeW-1:0] mode,
  input logic [wcc_pkg::SecW-1:0]  remaining_seconds,
  input logic                      rejected
);
  import wcc_pkg::*;

  // Pump and lamp follow the watering mode on every result beat.
  a_drive_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pump_on == led_on) && (pump_on == (mode == MODE_WATERING)))
    else $error("pump or lamp disagrees with mode");

  // An idle result never shows time left.
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && mode == MODE_IDLE) |-> remaining_seconds == '0)
    else $error("idle result with nonzero remaining time");

  // No result beat is offered in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  // A stalled result beat holds its payload.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(mode) &&
      $stable(remaining_seconds) && $stable(rejected))
    else $error("stalled result beat changed");

endmodule

bind watering_cycle_controller_core wcc_checker u_wcc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_bus.valid),
  .out_ready         (out_bus.ready),
  .pump_on           (out_bus.pump_on),
  .led_on            (out_bus.led_on),
  .mode              (out_bus.mode),
  .remaining_seconds (out_bus.remaining_seconds),
  .rejected          (out_bus.rejected)
);
